// ----- hw/rtl/mmtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mmtu_pkg
// Types and constants shared by the machine-mode trap unit modules.
// ----------------------------------------------------------------------------
package mmtu_pkg;

  // Event kinds carried in the request tuser field.
  typedef enum logic [2:0] {
    OP_ECALL       = 3'd0,
    OP_ILLEGAL     = 3'd1,
    OP_LOAD_FAULT  = 3'd2,
    OP_STORE_FAULT = 3'd3,
    OP_FETCH_FAULT = 3'd4,
    OP_INTERRUPT   = 3'd5,
    OP_MRET        = 3'd6,
    OP_UNKNOWN     = 3'd7
  } opcode_t;

  // Result codes returned with every event.
  typedef enum logic [2:0] {
    RES_HANDLED      = 3'd0,
    RES_ECALL_HOST   = 3'd1,
    RES_ILLEGAL_HOST = 3'd2,
    RES_FAULT_HOST   = 3'd3,
    RES_UNIMPL       = 3'd4
  } result_code_t;

  // Configuration register indexes.
  localparam logic CFG_TRAP_OPTIONS = 1'b0;
  localparam logic CFG_TRAP_VECTOR  = 1'b1;

  // Option bits that hand an event kind to the host.
  localparam int OPT_ECALL   = 0;
  localparam int OPT_ILLEGAL = 1;
  localparam int OPT_LDST    = 2;
  localparam int OPT_FETCH   = 3;

  // Privilege levels.
  localparam logic [1:0] LEVEL_USER    = 2'd0;
  localparam logic [1:0] LEVEL_MACHINE = 2'd3;

  // Synchronous exception cause codes.
  localparam logic [3:0] CAUSE_FETCH_MISALIGNED = 4'd0;
  localparam logic [3:0] CAUSE_FETCH_FAULT      = 4'd1;
  localparam logic [3:0] CAUSE_ILLEGAL          = 4'd2;
  localparam logic [3:0] CAUSE_LOAD_MISALIGNED  = 4'd4;
  localparam logic [3:0] CAUSE_LOAD_FAULT       = 4'd5;
  localparam logic [3:0] CAUSE_STORE_MISALIGNED = 4'd6;
  localparam logic [3:0] CAUSE_STORE_FAULT      = 4'd7;
  localparam logic [1:0] CAUSE_ECALL_HI         = 2'b10;

  localparam int TDATA_IN_W  = 144;
  localparam int TDATA_OUT_W = 144;

  // One event as held in the input register.
  typedef struct packed {
    opcode_t     opcode;
    logic [63:0] current_pc;
    logic [63:0] fault_value;
    logic        misaligned;
    logic [7:0]  fault_code;
    logic [5:0]  interrupt_number;
  } event_t;

  // One result as held in the output register.
  typedef struct packed {
    result_code_t result_code;
    logic [63:0]  next_pc;
    logic         redirect;
    logic         interrupts_enabled;
    logic [7:0]   host_fault_code;
    logic [1:0]   current_level;
    logic [63:0]  recorded_cause;
  } result_t;

  // Configuration seen by the trap logic.
  typedef struct packed {
    logic [3:0]  trap_options;
    logic [63:0] trap_vector;
  } trap_cfg_t;

endpackage

// ----- hw/rtl/mmtu_trap_ctrl.sv -----
// ----------------------------------------------------------------------------
// mmtu_trap_ctrl
// Machine-mode trap state and the combinational event resolution logic.
// ----------------------------------------------------------------------------
module mmtu_trap_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  mmtu_pkg::event_t   ev,
  input  mmtu_pkg::trap_cfg_t cfg,
  output mmtu_pkg::result_t  res
);
  import mmtu_pkg::*;

  // Architectural trap state.
  logic [1:0]  priv_level, priv_level_next;
  logic        irq_enable, irq_enable_next;
  logic        prev_irq_enable, prev_irq_enable_next;
  logic [1:0]  prev_level, prev_level_next;
  logic [63:0] trap_cause, trap_cause_next;
  logic [63:0] exception_pc, exception_pc_next;
  logic [63:0] trap_value, trap_value_next;

  logic        take;
  logic        is_int;
  logic [3:0]  sync_cause;
  logic [63:0] cause;
  logic [63:0] vec_base;
  logic [63:0] vec_offset;
  logic [63:0] target;

  // Trap target: masked base, plus four times the cause for vectored interrupts.
  assign is_int     = (ev.opcode == OP_INTERRUPT);
  assign vec_base   = {cfg.trap_vector[63:2], 2'b00};
  assign vec_offset = (is_int && cfg.trap_vector[0]) ?
                      {56'd0, ev.interrupt_number, 2'b00} : 64'd0;
  assign target     = vec_base + vec_offset;
  assign cause      = is_int ? {1'b1, 57'd0, ev.interrupt_number} : {60'd0, sync_cause};

  // Decide the event outcome and the next trap state.
  always_comb begin
    take                 = 1'b0;
    sync_cause           = CAUSE_ILLEGAL;
    priv_level_next      = priv_level;
    irq_enable_next      = irq_enable;
    prev_irq_enable_next = prev_irq_enable;
    prev_level_next      = prev_level;
    trap_cause_next      = trap_cause;
    exception_pc_next    = exception_pc;
    trap_value_next      = trap_value;
    res.result_code      = RES_HANDLED;
    res.next_pc          = 64'd0;
    res.redirect         = 1'b0;
    res.host_fault_code  = 8'd0;

    case (ev.opcode)
      OP_ECALL: begin
        sync_cause = {CAUSE_ECALL_HI, priv_level};
        if (cfg.trap_options[OPT_ECALL]) res.result_code = RES_ECALL_HOST;
        else take = 1'b1;
      end
      OP_ILLEGAL: begin
        sync_cause = CAUSE_ILLEGAL;
        if (cfg.trap_options[OPT_ILLEGAL]) res.result_code = RES_ILLEGAL_HOST;
        else take = 1'b1;
      end
      OP_LOAD_FAULT, OP_STORE_FAULT: begin
        if (ev.opcode == OP_LOAD_FAULT)
          sync_cause = ev.misaligned ? CAUSE_LOAD_MISALIGNED : CAUSE_LOAD_FAULT;
        else
          sync_cause = ev.misaligned ? CAUSE_STORE_MISALIGNED : CAUSE_STORE_FAULT;
        if (cfg.trap_options[OPT_LDST]) begin
          res.result_code     = RES_FAULT_HOST;
          res.host_fault_code = ev.fault_code;
        end else begin
          take = 1'b1;
        end
      end
      OP_FETCH_FAULT: begin
        sync_cause = ev.misaligned ? CAUSE_FETCH_MISALIGNED : CAUSE_FETCH_FAULT;
        if (cfg.trap_options[OPT_FETCH]) begin
          res.result_code     = RES_FAULT_HOST;
          res.host_fault_code = ev.fault_code;
        end else begin
          take = 1'b1;
        end
      end
      OP_INTERRUPT: begin
        take = 1'b1;
      end
      OP_MRET: begin
        // Return is only legal from machine level.
        if (priv_level == LEVEL_MACHINE) begin
          irq_enable_next      = prev_irq_enable;
          prev_irq_enable_next = 1'b1;
          priv_level_next      = prev_level;
          prev_level_next      = LEVEL_USER;
          res.next_pc          = exception_pc;
          res.redirect         = 1'b1;
        end else begin
          res.result_code = RES_UNIMPL;
        end
      end
      default: begin
        res.result_code = RES_UNIMPL;
      end
    endcase

    // Trap entry records the event and moves to machine level.
    if (take) begin
      trap_cause_next      = cause;
      exception_pc_next    = ev.current_pc;
      trap_value_next      = ev.fault_value;
      prev_irq_enable_next = irq_enable;
      irq_enable_next      = 1'b0;
      prev_level_next      = priv_level;
      priv_level_next      = LEVEL_MACHINE;
      res.next_pc          = target;
      res.redirect         = 1'b1;
    end

    res.interrupts_enabled = irq_enable_next;
    res.current_level      = priv_level_next;
    res.recorded_cause     = trap_cause_next;
  end

  // State registers update when the event moves to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      priv_level      <= LEVEL_MACHINE;
      irq_enable      <= 1'b0;
      prev_irq_enable <= 1'b0;
      prev_level      <= LEVEL_USER;
      trap_cause      <= 64'd0;
      exception_pc    <= 64'd0;
      trap_value      <= 64'd0;
    end else if (fire) begin
      priv_level      <= priv_level_next;
      irq_enable      <= irq_enable_next;
      prev_irq_enable <= prev_irq_enable_next;
      prev_level      <= prev_level_next;
      trap_cause      <= trap_cause_next;
      exception_pc    <= exception_pc_next;
      trap_value      <= trap_value_next;
    end
  end

endmodule

// ----- hw/rtl/machine_mode_trap_unit_top.sv -----
// ----------------------------------------------------------------------------
// machine_mode_trap_unit_top
// Machine-mode trap entry and mret handling for a RISC-V core.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the s_axis channel (kind in s_tuser, operands in s_tdata)
//   and one result leaves on the m_axis channel for every event, in order.
//   The trap options and trap vector are written through the cfg channel,
//   which is always ready; write it only while no event is in flight.
// Datapath and throughput:
//   An event is captured in an input register, resolved by one level of
//   decode and a 64-bit vector add, and lands in the output register.
//   One event per cycle is sustained while m_tready stays high, since the
//   trap state updates in the same cycle as the result is registered.
// Reset:
//   rst clears both stages, the configuration registers and the trap state
//   (machine level, interrupts disabled, recorded registers zero).
// Stalls:
//   While m_tready is low the result holds; the input register still takes
//   one more request, then s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module machine_mode_trap_unit_top (
  input  logic                              clk,
  input  logic                              rst,
  // Event requests.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [63:0] current_pc, [127:64] fault_value, [128] misaligned,
  // [136:129] fault_code, [142:137] interrupt_number, [143] zero
  input  logic [mmtu_pkg::TDATA_IN_W-1:0]   s_tdata,
  // [2:0] opcode
  input  logic [2:0]                        s_tuser,
  // Results.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [63:0] next_pc, [64] redirect, [65] interrupts_enabled,
  // [73:66] host_fault_code, [75:74] current_level,
  // [139:76] recorded_cause, [143:140] zero
  output logic [mmtu_pkg::TDATA_OUT_W-1:0]  m_tdata,
  // [2:0] result_code
  output logic [2:0]                        m_tuser,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [63:0]                       cfg_data
);
  import mmtu_pkg::*;

  logic      in_valid;
  event_t    in_item;
  logic      fire;
  result_t   res;
  result_t   out_item;
  trap_cfg_t cfg;

  // Input stage advances whenever the output register is free or draining.
  assign fire      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trap_options <= 4'd0;
      cfg.trap_vector  <= 64'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TRAP_OPTIONS: cfg.trap_options <= cfg_data[3:0];
        CFG_TRAP_VECTOR:  cfg.trap_vector  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode           <= opcode_t'(s_tuser);
      in_item.current_pc       <= s_tdata[63:0];
      in_item.fault_value      <= s_tdata[127:64];
      in_item.misaligned       <= s_tdata[128];
      in_item.fault_code       <= s_tdata[136:129];
      in_item.interrupt_number <= s_tdata[142:137];
    end
  end

  mmtu_trap_ctrl u_trap_ctrl (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .ev  (in_item),
    .cfg (cfg),
    .res (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= res;
    end
  end

  assign m_tuser = out_item.result_code;
  assign m_tdata = {4'd0,
                    out_item.recorded_cause,
                    out_item.current_level,
                    out_item.host_fault_code,
                    out_item.interrupts_enabled,
                    out_item.redirect,
                    out_item.next_pc};

endmodule
